[sv/color_gradient_stop_table_defines.svh]
// Assertion macros for the gradient stop table.
// Included by the top level; no other dependencies.
`ifndef COLOR_GRADIENT_STOP_TABLE_DEFINES_SVH
`define COLOR_GRADIENT_STOP_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CGST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define CGST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/cgst_pkg.sv]
// Shared types and constants for the gradient stop table.
// No dependencies.
package cgst_pkg;
	localparam int MaxStops = 16;
	localparam int CntW = $clog2(MaxStops + 1);
	localparam int PosW = 17;
	localparam int ChW = 16;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_ADD = 1'b1;

	localparam logic [1:0] ST_LOOKUP = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_REPLACE = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [ChW-1:0] a;
		logic [ChW-1:0] b;
		logic [ChW-1:0] g;
		logic [ChW-1:0] r;
	} color_t;

	typedef struct packed {
		logic [PosW-1:0] pos;
		color_t col;
	} stop_t;

	// Per-cell control, driven from the sequencer.
	typedef struct packed {
		logic shift;     // take neighbor's stop (toward cell 0 in a scan, away in an insert)
		logic load;      // load the new stop into the cell
		logic recolor;   // replace color where position matches
	} cell_ctl_t;
endpackage

[sv/color_gradient_stop_table.sv]
// Top level of the gradient stop table: cell chain, sequencer and blend unit.
// Depends on cgst_pkg, cgst_cell, cgst_div and the defines header.
//
// Channel | Valid     | Stall     | Payload
// input   | in_valid  | in_stall  | command, position, red/green/blue/alpha_in
// output  | out_valid | out_stall | red/green/blue/alpha_out, status
//
// Every transaction rotates the occupied cells once around, one stop per cycle
// (2 to 16 stops), comparing the stop at cell 0 each cycle. A replace, a full add
// or an unblended lookup then goes to S_WAIT; an insert first makes room in S_INS,
// and a blended lookup first runs the divider once per channel. The result waits
// in an output register; the next transaction is taken when the block is idle and
// that register is empty or being drained. Reset loads the two stops.
`include "color_gradient_stop_table_defines.svh"
module color_gradient_stop_table import cgst_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            command,
	input  logic [PosW-1:0] position,
	input  logic [ChW-1:0]  red_in,
	input  logic [ChW-1:0]  green_in,
	input  logic [ChW-1:0]  blue_in,
	input  logic [ChW-1:0]  alpha_in,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [ChW-1:0]  red_out,
	output logic [ChW-1:0]  green_out,
	output logic [ChW-1:0]  blue_out,
	output logic [ChW-1:0]  alpha_out,
	output logic [1:0]      status
);
	localparam int IdxW = $clog2(MaxStops);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [2:0] state_q;
	logic cmd_q;
	stop_t new_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] step_q;
	logic hit_q, found_q, first_q;
	stop_t lo_q, hi_q, prev_q;
	logic [1:0] ch_q;
	color_t res_q;
	logic [1:0] st_q;
	logic ovalid_q;

	stop_t cur [MaxStops];
	cell_ctl_t ctl [MaxStops];
	stop_t rst_v [MaxStops];

	logic accept;
	assign in_stall = (state_q != S_IDLE) || (ovalid_q && out_stall);
	assign accept = in_valid && !in_stall;

	// Insert slot: the first stop above the new position, or the slot after the
	// last stop if none is; rotating n more steps from an empty tail needs care,
	// so inserts shift cells at and above the slot instead.
	logic [IdxW-1:0] ins_at_q;

	// Cell chain: cell i takes cell i+1 during the scan rotation (ring of cnt).
	for (genvar i = 0; i < MaxStops; i++) begin : g_cell
		stop_t nbr;
		always_comb begin
			rst_v[i] = '0;
			if (i == 0) rst_v[i].col.a = '1;
			if (i == 1) begin
				rst_v[i].pos = PosW'(65536);
				rst_v[i].col = '1;
			end
			ctl[i] = '0;
			nbr = cur[(i + 1) % MaxStops];
			if (state_q == S_SCAN) begin
				// Rotate only the occupied ring 0..cnt-1.
				ctl[i].shift = (CntW'(i) < cnt_q);
				if (CntW'(i) == cnt_q - 1'b1) nbr = cur[0];
				ctl[i].recolor = cmd_q == CMD_ADD;
			end else if (state_q == S_INS) begin
				// Make room: cells above the slot take the one below.
				if (i > 0 && IdxW'(i) > ins_at_q && CntW'(i) <= cnt_q) begin
					ctl[i].shift = 1'b1;
					nbr = cur[(i + MaxStops - 1) % MaxStops];
				end
				ctl[i].load = IdxW'(i) == ins_at_q;
			end
		end
		cgst_cell u_cell (
			.clk(clk), .arst_n(arst_n), .rst_val(rst_v[i]), .nbr(nbr),
			.new_stop(new_q), .ctl(ctl[i]), .cur(cur[i])
		);
	end

	// Blend operands for the current channel.
	logic [ChW-1:0] c0, c1, dmag;
	logic [PosW-1:0] den;
	logic [ChW+PosW-1:0] prod;
	logic div_done;
	logic [ChW-1:0] quo;
	logic div_start;
	always_comb begin
		case (ch_q)
			2'd0: begin c0 = lo_q.col.r; c1 = hi_q.col.r; end
			2'd1: begin c0 = lo_q.col.g; c1 = hi_q.col.g; end
			2'd2: begin c0 = lo_q.col.b; c1 = hi_q.col.b; end
			default: begin c0 = lo_q.col.a; c1 = hi_q.col.a; end
		endcase
		dmag = (c1 >= c0) ? c1 - c0 : c0 - c1;
		den = hi_q.pos - lo_q.pos;
	end
	logic [ChW+PosW-1:0] prod_s1;
	assign prod = (ChW+PosW)'(dmag) * (ChW+PosW)'(new_q.pos - lo_q.pos);

	cgst_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod_s1),
		.den(den), .done(div_done), .quo(quo)
	);

	logic [ChW-1:0] blended;
	assign blended = (c1 >= c0) ? c0 + quo : c0 - quo;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= CntW'(2);
			ovalid_q <= 1'b0;
			div_start <= 1'b0;
		end else begin
			// Result register: set once a result is ready, cleared when it is taken.
			if (state_q == S_WAIT) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			div_start <= (state_q == S_DIV) && (step_q == IdxW'(1));
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= command;
						new_q <= {position, alpha_in, blue_in, green_in, red_in};
						step_q <= '0;
						hit_q <= 1'b0;
						found_q <= 1'b0;
						ins_at_q <= IdxW'(cnt_q);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// cur[0] holds stop number step_q.
					prev_q <= cur[0];
					if (cmd_q == CMD_ADD) begin
						if (cur[0].pos == new_q.pos) hit_q <= 1'b1;
						if (!found_q && cur[0].pos > new_q.pos) begin
							found_q <= 1'b1;
							ins_at_q <= step_q;
						end
					end else if (!found_q && new_q.pos <= cur[0].pos) begin
						found_q <= 1'b1;
						first_q <= step_q == '0;
						lo_q <= prev_q;
						hi_q <= cur[0];
					end
					if (CntW'(step_q) == cnt_q - 1'b1) begin
						step_q <= '0;
						if (cmd_q == CMD_ADD) begin
							res_q <= '0;
							if (hit_q || cur[0].pos == new_q.pos) begin
								st_q <= ST_REPLACE;
								state_q <= S_WAIT;
							end else if (cnt_q >= CntW'(MaxStops)) begin
								st_q <= ST_FULL;
								state_q <= S_WAIT;
							end else begin
								st_q <= ST_INSERT;
								state_q <= S_INS;
							end
						end else begin
							st_q <= ST_LOOKUP;
							if (!found_q && new_q.pos > cur[0].pos) begin
								res_q <= cur[0].col;
								state_q <= S_WAIT;
							end else if ((found_q && first_q) ||
									(!found_q && step_q == '0)) begin
								res_q <= found_q ? hi_q.col : cur[0].col;
								state_q <= S_WAIT;
							end else begin
								ch_q <= 2'd0;
								state_q <= S_DIV;
							end
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_INS: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_WAIT;
				end
				S_DIV: begin
					// step_q: 0 = register product, 1 = start, then wait.
					if (step_q == '0) begin
						prod_s1 <= prod;
						step_q <= IdxW'(1);
					end else if (step_q == IdxW'(1)) begin
						step_q <= IdxW'(2);
					end else if (div_done) begin
						case (ch_q)
							2'd0: res_q.r <= blended;
							2'd1: res_q.g <= blended;
							2'd2: res_q.b <= blended;
							default: res_q.a <= blended;
						endcase
						step_q <= '0;
						ch_q <= ch_q + 1'b1;
						if (ch_q == 2'd3) state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign red_out = res_q.r;
	assign green_out = res_q.g;
	assign blue_out = res_q.b;
	assign alpha_out = res_q.a;
	assign status = st_q;

	`CGST_ASSERT_IMP(a_count_range, 1'b1, cnt_q >= CntW'(2) && cnt_q <= CntW'(MaxStops), "stop count out of range")
	`CGST_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, in_stall, "input taken while busy")
	`CGST_ASSERT_NXT(a_insert_grows, state_q == S_INS, cnt_q == $past(cnt_q) + 1'b1, "insert lost count")
endmodule

[sv/cgst_cell.sv]
// One stop cell of the table chain: holds a stop and takes its neighbor's.
// Depends on cgst_pkg.
module cgst_cell import cgst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stop_t     rst_val,
	input  stop_t     nbr,
	input  stop_t     new_stop,
	input  cell_ctl_t ctl,
	output stop_t     cur
);
	stop_t stop_q;
	stop_t taken;

	// The neighbor's stop, with its color replaced when its position matches the new stop.
	always_comb begin
		taken = nbr;
		if (ctl.recolor && nbr.pos == new_stop.pos) taken.col = new_stop.col;
	end

	// Reset value, load the new stop, or take the neighbor's stop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= rst_val;
		end else if (ctl.load) begin
			stop_q <= new_stop;
		end else if (ctl.shift) begin
			stop_q <= taken;
		end
	end

	assign cur = stop_q;
endmodule

[sv/cgst_div.sv]
// Restoring divider: quotient of a 33-bit numerator by a 17-bit divisor.
// One quotient bit per cycle; depends on cgst_pkg.
module cgst_div import cgst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ChW+PosW-1:0]  num,
	input  logic [PosW-1:0]      den,
	output logic                 done,
	output logic [ChW-1:0]       quo
);
	localparam int NW = ChW + PosW;
	localparam int BW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [PosW:0] rem_q;
	logic [PosW-1:0] den_q;
	logic [BW-1:0] bits_q;
	logic busy_q;
	logic [PosW:0] trial;
	logic [PosW+1:0] diff;

	assign trial = {rem_q[PosW-1:0], num_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};

	// Shift in one numerator bit each cycle and subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bits_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bits_q <= BW'(NW);
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
			end else if (busy_q) begin
				if (!diff[PosW+1]) begin
					rem_q <= diff[PosW:0];
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				bits_q <= bits_q - 1'b1;
				if (bits_q == BW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Quotient fits 16 bits since num < den * 65536.
	assign quo = num_q[ChW-1:0];
endmodule
